FILE: hdl/image_twofold_resampler_core_macros.svh
// Assertion macros shared by the resampler RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef IMAGE_TWOFOLD_RESAMPLER_CORE_MACROS_SVH
`define IMAGE_TWOFOLD_RESAMPLER_CORE_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define IRCR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRCR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/ircr_pkg.sv
// Types, constants and channel arithmetic for the two-fold resampler.
// No dependencies.
package ircr_pkg;

  localparam int unsigned CHAN_W      = 16;
  localparam int unsigned COORD_W     = 11;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = 2;
  localparam int unsigned FIFO_LVL_W  = 3;

  localparam logic [1:0] MODE_HALVE_H  = 2'd0;
  localparam logic [1:0] MODE_HALVE_V  = 2'd1;
  localparam logic [1:0] MODE_DOUBLE_H = 2'd2;
  localparam logic [1:0] MODE_DOUBLE_V = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // Upsample result kinds, in the order they leave the block.
  localparam logic [1:0] KIND_BEFORE    = 2'd0;
  localparam logic [1:0] KIND_AT        = 2'd1;
  localparam logic [1:0] KIND_WRAP_NEXT = 2'd2;
  localparam logic [1:0] KIND_WRAP_ZERO = 2'd3;

  typedef logic [3:0][CHAN_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t             cur;
    pixel_t             nb;
    pixel_t             fst;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [1:0]         mode;
    logic               pair;
    logic               wrap;
  } job_t;

  typedef struct packed {
    logic                  full;
    logic [FIFO_LVL_W-1:0] level;
  } fifo_stat_t;

  typedef struct packed {
    logic at_origin;
    logic stage_valid;
  } front_stat_t;

  function automatic pixel_t px_average(pixel_t a, pixel_t b);
    logic [CHAN_W:0] s;
    pixel_t          r;
    for (int i = 0; i < 4; i++) begin
      s    = (CHAN_W+1)'(a[i]) + (CHAN_W+1)'(b[i]) + (CHAN_W+1)'(1);
      r[i] = s[CHAN_W:1];
    end
    return r;
  endfunction

  // One quarter of far plus three quarters of near, rounded to nearest.
  function automatic pixel_t px_blend(pixel_t far_px, pixel_t near_px);
    logic [CHAN_W+1:0] s;
    pixel_t            r;
    for (int i = 0; i < 4; i++) begin
      s    = (CHAN_W+2)'(far_px[i]) + (CHAN_W+2)'(near_px[i])
           + ((CHAN_W+2)'(near_px[i]) << 1) + (CHAN_W+2)'(2);
      r[i] = s[CHAN_W+1:2];
    end
    return r;
  endfunction

endpackage

FILE: hdl/ircr_front.sv
// Front end: position counters, edge pixels, line stores and job classification.
// Depends on ircr_pkg.
module ircr_front import ircr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pixel_t               pix_i,
  input  fifo_stat_t           fifo_stat_i,
  output logic                 push_o,
  output job_t                 job_o,
  output front_stat_t          stat_o
);

  localparam int unsigned CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [1:0]       mode_q;
  logic [CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  pixel_t           prev_q, firstpix_q;
  pixel_t           prev_row_mem  [MAX_WIDTH];
  pixel_t           first_row_mem [MAX_WIDTH];

  logic             st_valid_q;
  pixel_t           st_cur_q, st_prev_q, st_first_q, st_above_q, st_frow_q;
  logic [CW-1:0]    st_col_q;
  logic [RW-1:0]    st_row_q;
  logic [1:0]       st_mode_q;
  logic             st_lastc_q, st_lastr_q;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          last_col, last_row, accept;
  pixel_t        frow;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign last_col = ((WW+1)'(col_q) + (WW+1)'(1)) >= (WW+1)'(w_eff);
  assign last_row = ((HW+1)'(row_q) + (HW+1)'(1)) >= (HW+1)'(h_eff);

  // Room is kept for the job already in the stage register.
  assign in_stall_o = ((FIFO_LVL_W+1)'(fifo_stat_i.level) + (FIFO_LVL_W+1)'(st_valid_q))
                      >= (FIFO_LVL_W+1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HALVE_H;
      width_q    <= CFG_W'(1024);
      height_q   <= CFG_W'(1024);
      col_q      <= '0;
      row_q      <= '0;
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= accept;
      if (accept) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE: begin
            mode_q <= cfg_data_i[1:0];
            col_q  <= '0;
            row_q  <= '0;
          end
          REG_WIDTH: begin
            width_q <= cfg_data_i;
            col_q   <= '0;
            row_q   <= '0;
          end
          REG_HEIGHT: begin
            height_q <= cfg_data_i;
            col_q    <= '0;
            row_q    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Line stores read the old entry while the current pixel overwrites it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q <= pix_i;
      if (col_q == '0) begin
        firstpix_q <= pix_i;
      end
      prev_row_mem[col_q] <= pix_i;
      if (row_q == '0) begin
        first_row_mem[col_q] <= pix_i;
      end
      st_above_q <= prev_row_mem[col_q];
      st_frow_q  <= first_row_mem[col_q];
      st_cur_q   <= pix_i;
      st_prev_q  <= prev_q;
      st_first_q <= (col_q == '0) ? pix_i : firstpix_q;
      st_col_q   <= col_q;
      st_row_q   <= row_q;
      st_mode_q  <= mode_q;
      st_lastc_q <= last_col;
      st_lastr_q <= last_row;
    end
  end

  assign frow = (st_row_q == '0) ? st_cur_q : st_frow_q;

  always_comb begin
    job_o.cur  = st_cur_q;
    job_o.mode = st_mode_q;
    job_o.col  = COORD_W'(st_col_q);
    job_o.row  = COORD_W'(st_row_q);
    job_o.nb   = st_prev_q;
    job_o.fst  = st_first_q;
    job_o.pair = 1'b0;
    job_o.wrap = 1'b0;
    case (st_mode_q)
      MODE_HALVE_H: begin
        job_o.pair = st_col_q[0];
        job_o.col  = COORD_W'(st_col_q >> 1);
      end
      MODE_HALVE_V: begin
        job_o.pair = st_row_q[0];
        job_o.nb   = st_above_q;
        job_o.row  = COORD_W'(st_row_q >> 1);
      end
      MODE_DOUBLE_H: begin
        job_o.pair = st_col_q != '0;
        job_o.wrap = st_lastc_q;
      end
      default: begin
        job_o.pair = st_row_q != '0;
        job_o.wrap = st_lastr_q;
        job_o.nb   = st_above_q;
        job_o.fst  = frow;
      end
    endcase
  end

  assign push_o             = st_valid_q;
  assign stat_o.at_origin   = (col_q == '0) && (row_q == '0);
  assign stat_o.stage_valid = st_valid_q;

endmodule

FILE: hdl/ircr_fifo.sv
// Short job queue between the front end and the result sequencer.
// Depends on ircr_pkg.
module ircr_fifo import ircr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output job_t       job_o,
  output fifo_stat_t stat_o
);

  job_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_LVL_W-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_PTR_W'(1);
      end
      level_q <= level_q + FIFO_LVL_W'(push_i) - FIFO_LVL_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign job_o        = mem_q[rd_q];
  assign stat_o.level = level_q;
  assign stat_o.full  = level_q == FIFO_LVL_W'(FIFO_DEPTH);

endmodule

FILE: hdl/ircr_back.sv
// Result sequencer: turns each job into its zero to four output pixels.
// Depends on ircr_pkg.
module ircr_back import ircr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               job_i,
  input  fifo_stat_t         fifo_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pixel_t             pix_o,
  output logic [COORD_W-1:0] col_o,
  output logic [COORD_W-1:0] row_o,
  output logic               last_o
);

  logic [1:0]         step_q;
  logic               ov_q;
  pixel_t             pix_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic               last_q;

  logic               have, can_load, load, is_last, up, horiz;
  logic [2:0]         n_res;
  logic [1:0]         kind;
  logic [COORD_W-1:0] p, p2, coord;
  pixel_t             res;

  assign up    = job_i.mode[1];
  assign horiz = job_i.mode == MODE_DOUBLE_H;
  assign n_res = up ? ({1'b0, job_i.pair, 1'b0} + {1'b0, job_i.wrap, 1'b0})
                    : {2'b00, job_i.pair};
  assign have     = fifo_stat_i.level != '0;
  assign can_load = !ov_q || !out_stall_i;
  assign load     = have && (n_res != '0) && can_load;
  assign is_last  = 3'(step_q) + 3'(1) == n_res;
  assign pop_o    = have && ((n_res == '0) || (can_load && is_last));

  // Without the pair results the sequence starts at the wrap results.
  assign kind = job_i.pair ? step_q : step_q + 2'd2;
  assign p    = horiz ? job_i.col : job_i.row;
  assign p2   = p << 1;

  always_comb begin
    case (kind)
      KIND_BEFORE: begin
        res   = px_blend(job_i.cur, job_i.nb);
        coord = p2 - COORD_W'(1);
      end
      KIND_AT: begin
        res   = px_blend(job_i.nb, job_i.cur);
        coord = p2;
      end
      KIND_WRAP_NEXT: begin
        res   = px_blend(job_i.fst, job_i.cur);
        coord = p2 + COORD_W'(1);
      end
      default: begin
        res   = px_blend(job_i.cur, job_i.fst);
        coord = '0;
      end
    endcase
    if (!up) begin
      res = px_average(job_i.nb, job_i.cur);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (load) begin
        ov_q   <= 1'b1;
        step_q <= is_last ? '0 : step_q + 2'd1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q  <= res;
      last_q <= is_last;
      col_q  <= job_i.col;
      row_q  <= job_i.row;
      if (up && horiz) begin
        col_q <= coord;
      end else if (up) begin
        row_q <= coord;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign pix_o       = pix_q;
  assign col_o       = col_q;
  assign row_o       = row_q;
  assign last_o      = last_q;

endmodule

FILE: hdl/image_twofold_resampler_core.sv
// Top level of the two-fold image resampler: front end, job queue, sequencer.
// Depends on ircr_pkg, ircr_front, ircr_fifo, ircr_back and the macros header.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------
//   cfg     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//   in      | in_valid_i / in_stall_o  | red/green/blue/alpha_in_i
//   out     | out_valid_o / out_stall_i| red/green/blue/alpha_out_o, coords, last
//
// A pixel enters every cycle while the four-entry job queue has room.
// Each job leaves one result per cycle while out_stall_i is low; a pixel holds the sequencer
// until its last result (one, two or four) is loaded, and a pixel with no result is just popped.
// An accepted pixel passes the stage register, the job queue and the output register to its first result.
// Reset clears counters, queue and output valid; the line stores need no clear.
`include "image_twofold_resampler_core_macros.svh"
module image_twofold_resampler_core import ircr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CHAN_W-1:0]    red_in_i,
  input  logic [CHAN_W-1:0]    green_in_i,
  input  logic [CHAN_W-1:0]    blue_in_i,
  input  logic [CHAN_W-1:0]    alpha_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CHAN_W-1:0]    red_out_o,
  output logic [CHAN_W-1:0]    green_out_o,
  output logic [CHAN_W-1:0]    blue_out_o,
  output logic [CHAN_W-1:0]    alpha_out_o,
  output logic [COORD_W-1:0]   out_column_o,
  output logic [COORD_W-1:0]   out_row_o,
  output logic                 last_of_run_o
);

  pixel_t      in_pix, out_pix;
  job_t        push_job, head_job;
  logic        push, pop;
  fifo_stat_t  fifo_stat;
  front_stat_t front_stat;
  logic        cfg_restart;

  assign in_pix = {alpha_in_i, blue_in_i, green_in_i, red_in_i};

  ircr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pix_i       (in_pix),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .job_o       (push_job),
    .stat_o      (front_stat)
  );

  ircr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (fifo_stat)
  );

  ircr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pix_o       (out_pix),
    .col_o       (out_column_o),
    .row_o       (out_row_o),
    .last_o      (last_of_run_o)
  );

  assign red_out_o   = out_pix[0];
  assign green_out_o = out_pix[1];
  assign blue_out_o  = out_pix[2];
  assign alpha_out_o = out_pix[3];

  assign cfg_restart = cfg_we_i && (cfg_idx_i <= REG_HEIGHT);

  `IRCR_ASSERT_NEVER(a_queue_overflow, push && fifo_stat.full && !pop, "job queue overflow")
  `IRCR_ASSERT_NEVER(a_queue_underflow, pop && (fifo_stat.level == '0), "pop from empty queue")
  `IRCR_ASSERT_NEXT(a_cfg_restart, cfg_restart, front_stat.at_origin, "image not restarted")

endmodule
